@@ rtl/csvqfs_pkg.sv @@
// ----------------------------------------------------------------------------
// csvqfs_pkg
// Shared types, codes and the whitespace test for the CSV field splitter.
// ----------------------------------------------------------------------------
package csvqfs_pkg;

	localparam int unsigned CharW = 16;

	localparam logic [CharW-1:0] QuoteChar = 16'h0022;
	localparam logic [CharW-1:0] SepReset  = 16'h002C;

	typedef enum logic [1:0] {
		MODE_PLAIN   = 2'd0,
		MODE_QUOTED  = 2'd1,
		MODE_PENDING = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ACT_APPEND  = 2'd0,
		ACT_END     = 2'd1,
		ACT_RESTART = 2'd2
	} action_t;

	// One character step: optional result and the state it leaves.
	typedef struct packed {
		logic             emit;
		action_t          act;
		logic [CharW-1:0] ch;
		mode_t            mode_nxt;
		logic             blank_nxt;
	} step_t;

	function automatic logic is_space(input logic [CharW-1:0] c);
		logic r;
		begin
			r = 1'b0;
			if (c inside {[16'h0009:16'h000D], 16'h0020, 16'h0085, 16'h00A0, 16'h1680,
				[16'h2000:16'h200A], 16'h2028, 16'h2029, 16'h202F, 16'h205F,
				16'h3000}) begin
				r = 1'b1;
			end
			return r;
		end
	endfunction

endpackage

@@ rtl/csvqfs_decode.sv @@
// ----------------------------------------------------------------------------
// csvqfs_decode
// Quote state machine step for one character: result and next state.
// ----------------------------------------------------------------------------
module csvqfs_decode (
	input  logic                                 has_char,
	input  logic [csvqfs_pkg::CharW-1:0]         char_code,
	input  logic [csvqfs_pkg::CharW-1:0]         sep,
	input  csvqfs_pkg::mode_t                    mode,
	input  logic                                 blank,
	output csvqfs_pkg::step_t                    step
);

	logic is_quote;
	logic blank_app;
	logic plain_path;

	assign is_quote  = (char_code == csvqfs_pkg::QuoteChar);
	assign blank_app = blank & csvqfs_pkg::is_space(char_code);

	always_comb begin
		step.emit      = 1'b0;
		step.act       = csvqfs_pkg::ACT_APPEND;
		step.ch        = '0;
		step.mode_nxt  = mode;
		step.blank_nxt = blank;
		plain_path     = 1'b0;

		if (has_char) begin
			case (mode)
				csvqfs_pkg::MODE_QUOTED: begin
					if (is_quote) begin
						step.mode_nxt = csvqfs_pkg::MODE_PENDING;
					end else begin
						step.emit      = 1'b1;
						step.ch        = char_code;
						step.blank_nxt = blank_app;
					end
				end
				csvqfs_pkg::MODE_PENDING: begin
					if (is_quote) begin
						// doubled quote: literal
						step.emit      = 1'b1;
						step.ch        = char_code;
						step.mode_nxt  = csvqfs_pkg::MODE_QUOTED;
						step.blank_nxt = 1'b0;
					end else begin
						plain_path = 1'b1;
					end
				end
				default: begin
					plain_path = 1'b1;
				end
			endcase

			if (plain_path) begin
				step.emit     = 1'b1;
				step.mode_nxt = csvqfs_pkg::MODE_PLAIN;
				if (is_quote && blank) begin
					step.act      = csvqfs_pkg::ACT_RESTART;
					step.mode_nxt = csvqfs_pkg::MODE_QUOTED;
				end else if (char_code == sep) begin
					step.act       = csvqfs_pkg::ACT_END;
					step.blank_nxt = 1'b1;
				end else begin
					step.ch        = char_code;
					step.blank_nxt = blank_app;
				end
			end
		end
	end

endmodule

@@ rtl/csv_quoted_field_splitter.sv @@
// ----------------------------------------------------------------------------
// csv_quoted_field_splitter
// Splits a stream of UTF-16 record characters into field requests.
// ----------------------------------------------------------------------------
// Requests pass through an input register, a combinational decode and an
// output register. Throughput: one request per cycle, one result per cycle,
// while out_ready does not stall the output; a request that yields a
// character result and a record end holds the input register until both are
// sent. Reset clears valids and quote state and sets the separator to a comma.
module csv_quoted_field_splitter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [csvqfs_pkg::CharW-1:0]  cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [csvqfs_pkg::CharW-1:0]  char_code,
	input  logic                          has_char,
	input  logic                          record_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    action,
	output logic [csvqfs_pkg::CharW-1:0]  out_char,
	output logic                          ends_record,
	output logic                          last_of_run
);

	logic [csvqfs_pkg::CharW-1:0] sep_q;
	csvqfs_pkg::mode_t            mode_q;
	logic                         blank_q;

	logic                         valid_s1;
	logic [csvqfs_pkg::CharW-1:0] char_s1;
	logic                         has_s1;
	logic                         rend_s1;
	logic                         phase_q;

	csvqfs_pkg::action_t          act_q;
	logic [csvqfs_pkg::CharW-1:0] char_q;
	logic                         endrec_q;
	logic                         last_q;
	logic                         out_valid_q;

	csvqfs_pkg::step_t            dec;
	logic                         char_out;
	logic                         need_out;
	logic                         out_free;
	logic                         adv;
	logic                         finish;
	logic                         rec_close;

	csvqfs_decode u_decode (
		.has_char  (has_s1),
		.char_code (char_s1),
		.sep       (sep_q),
		.mode      (mode_q),
		.blank     (blank_q),
		.step      (dec)
	);

	assign char_out  = !phase_q && dec.emit;
	assign need_out  = phase_q || dec.emit || rend_s1;
	assign out_free  = !out_valid_q || out_ready;
	assign adv       = valid_s1 && (!need_out || out_free);
	assign finish    = adv && (phase_q || !(dec.emit && rend_s1));
	assign rec_close = rend_s1 && !char_out;
	assign in_ready  = !valid_s1 || finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= csvqfs_pkg::SepReset;
		end else if (cfg_wr_en) begin
			sep_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (finish) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			has_s1  <= has_char;
			rend_s1 <= record_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= csvqfs_pkg::MODE_PLAIN;
			blank_q <= 1'b1;
			phase_q <= 1'b0;
		end else if (adv) begin
			phase_q <= !finish;
			if (rec_close) begin
				mode_q  <= csvqfs_pkg::MODE_PLAIN;
				blank_q <= 1'b1;
			end else if (!phase_q) begin
				mode_q  <= dec.mode_nxt;
				blank_q <= dec.blank_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && need_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && need_out) begin
			if (char_out) begin
				act_q    <= dec.act;
				char_q   <= dec.ch;
				endrec_q <= 1'b0;
				last_q   <= !rend_s1;
			end else begin
				act_q    <= csvqfs_pkg::ACT_END;
				char_q   <= '0;
				endrec_q <= 1'b1;
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = act_q;
	assign out_char    = char_q;
	assign ends_record = endrec_q;
	assign last_of_run = last_q;

endmodule

@@ rtl/csvqfs_checker.sv @@
// ----------------------------------------------------------------------------
// csvqfs_checker
// Port-level checks on the field splitter's result stream.
// ----------------------------------------------------------------------------
module csvqfs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    action,
	input logic [csvqfs_pkg::CharW-1:0]  out_char,
	input logic                          ends_record,
	input logic                          last_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(out_char)
			&& $stable(ends_record) && $stable(last_of_run))
		else $error("result changed while stalled");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != csvqfs_pkg::ACT_APPEND) |-> out_char == '0)
		else $error("nonzero char on mark");

	a_rec_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ends_record |-> (action == csvqfs_pkg::ACT_END) && last_of_run)
		else $error("record end not a final end of field");

	a_act_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (action == csvqfs_pkg::ACT_APPEND) || (action == csvqfs_pkg::ACT_END)
			|| (action == csvqfs_pkg::ACT_RESTART))
		else $error("bad action code");

endmodule

bind csv_quoted_field_splitter csvqfs_checker u_csvqfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.action      (action),
	.out_char    (out_char),
	.ends_record (ends_record),
	.last_of_run (last_of_run)
);
